>>> sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define OVR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define OVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define OVR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/ovr_pkg.sv
package ovr_pkg;

    localparam int RING_DEPTH_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int HANDLE_W    = 32;
    localparam int IN_LEN_W    = 16;
    localparam int IN_POS_W    = 20;
    localparam int OUT_LEN_W   = 16;
    localparam int OFS_W       = 16;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic {
        MODE_ADD  = 1'b0,
        MODE_FIND = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SRCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [OFS_W-1:0]     offset_inside;
        logic [OUT_LEN_W-1:0] found_length;
        logic [HANDLE_W-1:0]  found_handle;
        logic                 found;
        logic [HANDLE_W-1:0]  displaced_handle;
        logic                 displaced_valid;
    } result_t;

    typedef struct packed {
        logic take_ready;
        logic res_load;
    } ctrl_status_t;

endpackage

>>> sv/overwriting_ring_with_offset_search.sv
// overwriting ring with byte offset search
//
// input stream (s_*): one request per item; s_tuser selects add (0) or find (1)
// output stream (m_*): exactly one result per request, in request order
// an add stores handle and length at the write pointer; on a full ring it
// overwrites the oldest entry and returns its handle with displaced_valid
// a find walks held entries oldest first and returns handle, length and
// inner offset of the entry holding the byte, or found = 0
// an add passes through ST_ADD, a find through ST_SRCH, walking skipped entries;
// both then wait in ST_EMIT until the output register is free to load the result
// one request at a time: no new request is taken until the last result is
// loaded; the find walk reads one entry per cycle through the single read port
// s_tready is high whenever the sequencer is idle, even while a result waits
// in the output register; a stalled m_tready holds the finished result there
// and the next result waits in the sequencer until the register frees up
// reset empties the ring and drops any pending result; entry memory needs no
// clearing since data from a slot that holds no entry is never used
module overwriting_ring_with_offset_search
    import ovr_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_handle [31:0], entry_length [47:32], byte_position [67:48], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode [0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // displaced_handle [31:0], found_handle [63:32], found_length [79:64],
    // offset_inside [95:80]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // displaced_valid [0], found [1]
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int DATA_W = HANDLE_W + LENGTH_BITS;

    ctrl_status_t             status;
    result_t                  result;
    logic                     out_free;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [DATA_W-1:0]        rd_data;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [OUT_TUSER_W-1:0]   m_tuser_reg;

    // output register can take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    // entry storage: {length, handle} per slot
    ovr_mem #(
        .DEPTH (RING_DEPTH),
        .WIDTH (DATA_W)
    ) u_mem (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    // pointers, fill count and search sequencer
    ovr_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (mode_t'(s_tuser[0])),
        .in_handle (s_tdata[31:0]),
        .in_length (s_tdata[47:32]),
        .in_pos    (s_tdata[67:48]),
        .out_free  (out_free),
        .status    (status),
        .result    (result),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign s_tready = status.take_ready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (status.res_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload only moves on a load, so it holds while stalled
    always_ff @(posedge clk)
    begin
        if (status.res_load)
        begin
            m_tdata_reg <= {result.offset_inside, result.found_length,
                            result.found_handle, result.displaced_handle};
            m_tuser_reg <= {result.found, result.displaced_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sv/ovr_mem.sv
module ovr_mem
    import ovr_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF,
    parameter int WIDTH = HANDLE_W + LENGTH_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> sv/ovr_ctrl.sv
module ovr_ctrl
    import ovr_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int AW     = $clog2(RING_DEPTH),
    localparam int CNT_W  = $clog2(RING_DEPTH + 1),
    localparam int DATA_W = HANDLE_W + LENGTH_BITS,
    localparam int POS_W  = (LENGTH_BITS > IN_POS_W) ? LENGTH_BITS : IN_POS_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mode_t                in_mode,
    input  logic [HANDLE_W-1:0]  in_handle,
    input  logic [IN_LEN_W-1:0]  in_length,
    input  logic [IN_POS_W-1:0]  in_pos,
    input  logic                 out_free,
    output ctrl_status_t         status,
    output result_t              result,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [DATA_W-1:0]    wr_data,
    output logic [AW-1:0]        rd_addr,
    input  logic [DATA_W-1:0]    rd_data
);

    state_t                 state_reg, state_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          rp_reg, rp_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [HANDLE_W-1:0]    hnd_reg, hnd_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    result_t                res_reg, res_next;

    logic [HANDLE_W-1:0]    rd_handle;
    logic [LENGTH_BITS-1:0] rd_len;
    logic [POS_W-1:0]       rd_len_ext;
    logic                   full;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(RING_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign rd_handle  = rd_data[HANDLE_W-1:0];
    assign rd_len     = rd_data[HANDLE_W +: LENGTH_BITS];
    assign rd_len_ext = POS_W'(rd_len);
    assign full       = (cnt_reg == CNT_W'(RING_DEPTH));

    assign wr_addr = wp_reg;
    assign wr_data = {len_reg, hnd_reg};
    assign result  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        pos_reg <= pos_next;
        hnd_reg <= hnd_next;
        len_reg <= len_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        hnd_next   = hnd_reg;
        len_next   = len_reg;
        res_next   = res_reg;
        status     = '0;
        wr_en      = 1'b0;
        rd_addr    = ptr_inc(idx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                status.take_ready = 1'b1;
                rd_addr = (in_mode == MODE_FIND) ? rp_reg : wp_reg;
                if (in_valid)
                begin
                    hnd_next = in_handle;
                    len_next = LENGTH_BITS'(32'(in_length));
                    pos_next = POS_W'(in_pos);
                    idx_next = rp_reg;
                    rem_next = cnt_reg;
                    state_next = (in_mode == MODE_FIND) ? ST_SRCH : ST_ADD;
                end
            end

            ST_ADD:
            begin
                // old entry at the write pointer is on rd_data now
                wr_en    = 1'b1;
                res_next = '0;
                if (full)
                begin
                    res_next.displaced_valid  = 1'b1;
                    res_next.displaced_handle = rd_handle;
                    rp_next = ptr_inc(rp_reg);
                end
                else
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
                wp_next    = ptr_inc(wp_reg);
                state_next = ST_EMIT;
            end

            ST_SRCH:
            begin
                if (rem_reg == '0)
                begin
                    res_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (rd_len_ext > pos_reg)
                begin
                    res_next               = '0;
                    res_next.found         = 1'b1;
                    res_next.found_handle  = rd_handle;
                    res_next.found_length  = OUT_LEN_W'(rd_len);
                    res_next.offset_inside = pos_reg[OFS_W-1:0];
                    state_next             = ST_EMIT;
                end
                else
                begin
                    // skip this entry, next one is being read
                    pos_next = pos_reg - rd_len_ext;
                    idx_next = ptr_inc(idx_reg);
                    rem_next = CNT_W'(rem_reg - 1'b1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    status.res_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/ovr_checker.sv
`include "assert_macros.svh"

module ovr_checker
    import ovr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // a stalled result holds still
    `OVR_ASSERT_NXT(a_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an add result never reports a find, and the other way round
    `OVR_ASSERT(a_one_kind, !(m_tvalid && m_tuser[0] && m_tuser[1]))

    // no displacement means zero displaced handle
    `OVR_ASSERT_IMP(a_disp_zero, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0)

    // a hit lies strictly inside its entry
    `OVR_ASSERT_IMP(a_ofs_inside, m_tvalid && m_tuser[1],
                    m_tdata[95:80] < m_tdata[79:64])

endmodule

bind overwriting_ring_with_offset_search ovr_checker u_ovr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb.sv
`timescale 1ns / 1ps

// checks the overwriting ring with byte offset search through its two streams
// every request is predicted at acceptance, the prediction queued and compared
// field by field against each result, in request order
module tb;
    import ovr_pkg::*;

    localparam int DEPTH          = RING_DEPTH_DEF;
    localparam int LEN_W          = LENGTH_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    // longest find walk plus pipeline, with margin
    localparam int DRAIN_CYCLES   = DEPTH + 16;
    localparam int MAX_REPORTS    = 10;

    // receiver stall patterns
    localparam int SINK_FULL  = 0;
    localparam int SINK_COIN  = 1;
    localparam int SINK_BURST = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // entry_handle [31:0], entry_length [47:32], byte_position [67:48], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata;
    // mode [0]
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // displaced_handle [31:0], found_handle [63:32], found_length [79:64],
    // offset_inside [95:80]
    logic [OUT_TDATA_W-1:0] m_tdata;
    // displaced_valid [0], found [1]
    logic [OUT_TUSER_W-1:0] m_tuser;

    overwriting_ring_with_offset_search u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow copy of the ring
    logic [HANDLE_W-1:0] shadow_handle [DEPTH];
    logic [LEN_W-1:0]    shadow_length [DEPTH];
    int                  wr_ptr;
    int                  rd_ptr;
    bit                  shadow_full;

    // predicted results waiting for the output stream
    result_t pending_results [$];

    int fail_count     = 0;
    int results_seen   = 0;
    int adds_sent      = 0;
    int finds_sent     = 0;
    int overwrites     = 0;
    int hits           = 0;
    int burst_left     = 0;
    int calm_left      = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int sink_mode      = SINK_FULL;
    logic [6:0] sink_phase = '0;

    result_t got_result;
    result_t want_result;

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // number of entries currently held
    function automatic int held_count();
        if (shadow_full)
            return DEPTH;
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    // total bytes in the oldest cnt held entries
    function automatic int unsigned held_prefix(int cnt);
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < cnt; k++)
            sum += shadow_length[(rd_ptr + k) % DEPTH];
        return sum;
    endfunction

    // apply one accepted request to the shadow ring and return its result
    function automatic result_t ring_apply(mode_t op, logic [HANDLE_W-1:0] handle,
                                           logic [IN_LEN_W-1:0] length,
                                           logic [IN_POS_W-1:0] position);
        result_t     res;
        int          n;
        int          idx;
        int unsigned remaining;
        bit          hit;
        res = '0;
        if (op == MODE_ADD)
        begin
            // full ring: the oldest entry sits at the write pointer
            if (shadow_full)
            begin
                res.displaced_valid  = 1'b1;
                res.displaced_handle = shadow_handle[wr_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
            end
            shadow_handle[wr_ptr] = handle;
            shadow_length[wr_ptr] = length[LEN_W-1:0];
            wr_ptr = (wr_ptr + 1) % DEPTH;
            shadow_full = (wr_ptr == rd_ptr);
        end
        else
        begin
            // walk held entries oldest first, zero-length ones hold no byte
            n = held_count();
            idx = rd_ptr;
            remaining = position;
            hit = 1'b0;
            for (int k = 0; k < n && !hit; k++)
            begin
                if (shadow_length[idx] > remaining)
                begin
                    hit = 1'b1;
                    res.found         = 1'b1;
                    res.found_handle  = shadow_handle[idx];
                    res.found_length  = shadow_length[idx];
                    res.offset_inside = remaining[OFS_W-1:0];
                end
                else
                begin
                    remaining -= shadow_length[idx];
                    idx = (idx + 1) % DEPTH;
                end
            end
        end
        return res;
    endfunction

    // offer one request, hold it until accepted, then queue its prediction
    task automatic send_request(mode_t op, logic [HANDLE_W-1:0] handle,
                                logic [IN_LEN_W-1:0] length, logic [IN_POS_W-1:0] position);
        int      gap;
        result_t res;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 5) == 0)
                calm_left = $urandom_range(4, 10);
            else if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - HANDLE_W - IN_LEN_W - IN_POS_W){1'b0}},
                     position, length, handle};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = ring_apply(op, handle, length, position);
        pending_results.push_back(res);
        if (op == MODE_ADD)
            adds_sent++;
        else
            finds_sent++;
        if (res.displaced_valid)
            overwrites++;
        if (res.found)
            hits++;
    endtask

    // searches on a freshly reset ring find nothing
    task automatic test_empty_ring();
        send_request(MODE_FIND, 32'h0, 16'h0, 20'h0);
        send_request(MODE_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF);
    endtask

    // zero, widest and one-byte entries, searched at their edges and past the end
    task automatic test_length_extremes();
        send_request(MODE_ADD, 32'h0000_0000, 16'h0000, 20'hFFFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'h0);
        send_request(MODE_ADD, 32'h5A5A_A5A5, 16'h0001, 20'hA5A5A);
        // zero-length entry is passed over
        send_request(MODE_FIND, 32'h0, 16'h0, 20'd0);
        send_request(MODE_FIND, 32'h0, 16'h0, 20'd65534);
        send_request(MODE_FIND, 32'h0, 16'h0, 20'd65535);
        // one past the held data, and far past it
        send_request(MODE_FIND, 32'h0, 16'h0, 20'd65536);
        send_request(MODE_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF);
    endtask

    // fill the ring, then overwrite the oldest entry and search the new head
    task automatic test_ring_overflow();
        for (int i = 1; i <= 13; i++)
            send_request(MODE_ADD, 32'h1000_0000 + i, IN_LEN_W'(i), IN_POS_W'($urandom));
        send_request(MODE_ADD, 32'h8000_0001, 16'd7, 20'h0);
        send_request(MODE_FIND, 32'h0, 16'h0, 20'd0);
    endtask

    // random adds and finds, positions mostly inside the held data
    task automatic test_random_traffic(int count);
        int unsigned total;
        int unsigned position;
        int          pick;
        int          k;
        logic [15:0] length;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 35)
            begin
                if (pick < 55)
                    length = 16'($urandom_range(1, 24));
                else if (pick < 70)
                    length = 16'h0;
                else if (pick < 90)
                    length = 16'($urandom);
                else
                    length = 16'(32'hFFFF - $urandom_range(0, 1));
                send_request(MODE_ADD, $urandom, length, IN_POS_W'($urandom));
            end
            else
            begin
                total = held_prefix(held_count());
                if (pick < 50)
                    position = $urandom_range(0, total);
                else if (pick < 75)
                begin
                    // entry boundaries, first byte or last byte before it
                    k = $urandom_range(0, held_count());
                    position = held_prefix(k);
                    if (position > 0 && $urandom_range(0, 1) == 1)
                        position--;
                end
                else if (pick < 90)
                    position = $urandom_range(0, (1 << IN_POS_W) - 1);
                else
                    position = (total > 0) ? total - $urandom_range(0, 1) : 0;
                send_request(MODE_FIND, $urandom, IN_LEN_W'($urandom),
                             IN_POS_W'(position));
            end
        end
    endtask

    // stop offering and let every predicted result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void note_mismatch(string what, result_t want, result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display({"%0t: %s, result %0d: ",
                      "expected dv=%0b dh=%h f=%0b fh=%h fl=%h oi=%h, ",
                      "got dv=%0b dh=%h f=%0b fh=%h fl=%h oi=%h"},
                     $realtime, what, results_seen,
                     want.displaced_valid, want.displaced_handle, want.found,
                     want.found_handle, want.found_length, want.offset_inside,
                     got.displaced_valid, got.displaced_handle, got.found,
                     got.found_handle, got.found_length, got.offset_inside);
    endfunction

    // result checker, one comparison per accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = '0;
            got_result.displaced_valid  = m_tuser[0];
            got_result.found            = m_tuser[1];
            got_result.displaced_handle = m_tdata[31:0];
            got_result.found_handle     = m_tdata[63:32];
            got_result.found_length     = m_tdata[79:64];
            got_result.offset_inside    = m_tdata[95:80];
            if (pending_results.size() == 0)
                note_mismatch("result with nothing pending", '0, got_result);
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.displaced_valid !== want_result.displaced_valid
                    || got_result.displaced_handle !== want_result.displaced_handle
                    || got_result.found !== want_result.found
                    || got_result.found_handle !== want_result.found_handle
                    || got_result.found_length !== want_result.found_length
                    || got_result.offset_inside !== want_result.offset_inside)
                    note_mismatch("field mismatch", want_result, got_result);
            end
            results_seen++;
        end
    end

    // receiver: full speed, coin flips or long stalls, picking a new mode whenever the 7-bit phase wraps
    always @(posedge clk)
    begin
        sink_phase <= sink_phase + 1'b1;
        if (sink_phase == '0)
            sink_mode <= $urandom_range(SINK_FULL, SINK_BURST);
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_FULL:
                    m_tready <= 1'b1;
                SINK_COIN:
                    m_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left <= $urandom_range(5, 30);
                        m_tready   <= 1'b0;
                    end
                    else
                        m_tready <= 1'b1;
                end
            endcase
        end
    end

    // watchdog on cycles with no request and no result accepted
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_ADD;
        m_tready <= 1'b0;
        wr_ptr      = 0;
        rd_ptr      = 0;
        shadow_full = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_ring();
        test_length_extremes();
        test_ring_overflow();
        test_random_traffic(1625);
        drain_results();

        $display("covered %0d adds (%0d overwrote the oldest entry) and %0d finds (%0d hits)",
                 adds_sent, overwrites, finds_sent, hits);
        $display("%0d results checked, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ovr_pkg.sv
sv/ovr_mem.sv
sv/ovr_ctrl.sv
sv/overwriting_ring_with_offset_search.sv
sv/ovr_checker.sv
test/tb.sv
